### rtl/tclb_pkg.sv
// ----------------------------------------------------------------------------
// tclb_pkg
// Shared types and constants for the text console line buffer.
// ----------------------------------------------------------------------------
package tclb_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned VIEW_ROW_W = 5;
   localparam int unsigned VIEW_COL_W = 7;
   localparam int unsigned CELL_W     = 16;

   localparam logic [CELL_W-1:0] CELL_COLOR = 16'h0F00;
   localparam logic [CHAR_W-1:0] RESET_PAD  = 8'd32;

   // beat function codes and the byte that ends a line
   localparam logic              FUNC_WRITE = 1'b0;
   localparam logic              FUNC_READ  = 1'b1;
   localparam logic [CHAR_W-1:0] LINE_END   = 8'h00;

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = 1;
   localparam int unsigned QUEUE_CW    = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_END   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CHAR_W-1:0]       char_byte;
      logic [VIEW_ROW_W-1:0]   view_row;
      logic [VIEW_COL_W-1:0]   view_col;
      logic                    in_range;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_RUN   = 2'd1,
      ST_PAD   = 2'd2
   } back_state_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

### rtl/text_console_line_buffer_core.sv
// ----------------------------------------------------------------------------
// text_console_line_buffer_core
// Scrolling text console: circular row store fed one line byte per beat.
// ----------------------------------------------------------------------------
// After reset the store, ROWS * 2**ceil(log2(COLS)) cells (3200 at the
// defaults), is swept to spaces one cell a cycle, with busy high.
// Beats then enter a two-entry command queue; the back end takes one
// command per cycle from it while it is not padding a row. A read's beat
// is registered in the queue, then in the read-pending flag and the cell
// register, which drive the strobe and the cell word. A zero byte ends the
// line: its command holds the back end while the rest of the row is
// padded one cell a cycle through the single store port, and busy rises
// once the queue fills. The strobe cannot be held off: results are lost if
// not taken in their cycle.
module text_console_line_buffer_core #(
   parameter int unsigned ROWS = 25,
   parameter int unsigned COLS = 80
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [tclb_pkg::CHAR_W-1:0]        req_char_byte,
   input  logic [tclb_pkg::VIEW_ROW_W-1:0]    req_view_row,
   input  logic [tclb_pkg::VIEW_COL_W-1:0]    req_view_col,
   output logic                               strobe,
   output logic [tclb_pkg::CELL_W-1:0]        rsp_cell_word,
   input  logic                               csr_write_en,
   input  logic [tclb_pkg::CHAR_W-1:0]        csr_write_data
);

   tclb_pkg::cmd_type           front_cmd;
   tclb_pkg::cmd_type           head_cmd;
   tclb_pkg::back_status_type   back_status;
   logic                        push;
   logic                        pop;
   logic                        queue_full;
   logic                        queue_valid;
   logic                        accept;

   assign busy   = queue_full | back_status.clearing;
   assign accept = start & ~busy;

   tclb_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .accept    (accept),
      .func      (req_func),
      .char_byte (req_char_byte),
      .view_row  (req_view_row),
      .view_col  (req_view_col),
      .push      (push),
      .cmd       (front_cmd)
   );

   tclb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head_cmd  (head_cmd)
   );

   tclb_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd_valid      (queue_valid),
      .cmd            (head_cmd),
      .cmd_pop        (pop),
      .status         (back_status),
      .strobe         (strobe),
      .rsp_cell_word  (rsp_cell_word)
   );

endmodule

### rtl/tclb_front.sv
// ----------------------------------------------------------------------------
// tclb_front
// Classifies an accepted beat into write, end-of-line or read command.
// ----------------------------------------------------------------------------
module tclb_front #(
   parameter int unsigned ROWS = 25,
   parameter int unsigned COLS = 80
) (
   input  logic                               accept,
   input  logic                               func,
   input  logic [tclb_pkg::CHAR_W-1:0]        char_byte,
   input  logic [tclb_pkg::VIEW_ROW_W-1:0]    view_row,
   input  logic [tclb_pkg::VIEW_COL_W-1:0]    view_col,
   output logic                               push,
   output tclb_pkg::cmd_type                  cmd
);

   logic row_ok;
   logic col_ok;

   assign row_ok = ({2'b00, view_row} < 7'(ROWS));
   assign col_ok = ({1'b0, view_col} < 8'(COLS));

   always_comb begin
      cmd.char_byte = char_byte;
      cmd.view_row  = view_row;
      cmd.view_col  = view_col;
      cmd.in_range  = row_ok & col_ok;
      if (func == tclb_pkg::FUNC_READ) begin
         cmd.op = tclb_pkg::OP_READ;
      end else if (char_byte == tclb_pkg::LINE_END) begin
         cmd.op = tclb_pkg::OP_END;
      end else begin
         cmd.op = tclb_pkg::OP_WRITE;
      end
   end

   assign push = accept;

endmodule

### rtl/tclb_queue.sv
// ----------------------------------------------------------------------------
// tclb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tclb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tclb_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output tclb_pkg::cmd_type   head_cmd
);

   tclb_pkg::cmd_type                      entry_ff [tclb_pkg::QUEUE_DEPTH];
   logic [tclb_pkg::QUEUE_AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [tclb_pkg::QUEUE_AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [tclb_pkg::QUEUE_CW-1:0]          count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign full      = (count_ff == tclb_pkg::QUEUE_CW'(tclb_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/tclb_back.sv
// ----------------------------------------------------------------------------
// tclb_back
// Executes commands against the row store: line writes, padding, cell reads.
// ----------------------------------------------------------------------------
module tclb_back #(
   parameter int unsigned ROWS = 25,
   parameter int unsigned COLS = 80
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [tclb_pkg::CHAR_W-1:0]    csr_write_data,
   input  logic                           cmd_valid,
   input  tclb_pkg::cmd_type              cmd,
   output logic                           cmd_pop,
   output tclb_pkg::back_status_type      status,
   output logic                           strobe,
   output logic [tclb_pkg::CELL_W-1:0]    rsp_cell_word
);

   localparam int unsigned RW    = $clog2(ROWS);
   localparam int unsigned CW    = $clog2(COLS + 1);
   localparam int unsigned CAW   = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int unsigned AW    = RW + CAW;
   localparam int unsigned DEPTH = ROWS << CAW;
   localparam int unsigned SW    = ((RW > tclb_pkg::VIEW_ROW_W) ? RW : tclb_pkg::VIEW_ROW_W) + 2;

   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0] COLS_C    = CW'(COLS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [SW-1:0] ROWS_S    = SW'(ROWS);

   logic [tclb_pkg::CHAR_W-1:0]  mem [DEPTH];
   logic [tclb_pkg::CHAR_W-1:0]  mem_q_ff;

   tclb_pkg::back_state_type     state_ff, state_in;
   logic [RW-1:0]                row_ff, row_in;
   logic [CW-1:0]                col_ff, col_in;
   logic                         line_open_ff, line_open_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;
   logic [tclb_pkg::CHAR_W-1:0]  pad_ff;
   logic                         rd_pending_ff, rd_pending_in;
   logic                         rd_zero_ff, rd_zero_in;

   logic                         mem_we;
   logic                         mem_re;
   logic [AW-1:0]                mem_addr;
   logic [tclb_pkg::CHAR_W-1:0]  mem_wdata;

   logic [RW-1:0]                row_next;
   logic [SW-1:0]                view_sum;
   logic [SW-1:0]                view_wrap;
   logic [RW-1:0]                view_phys;
   logic                         new_row;
   logic [RW-1:0]                wr_row;
   logic [CW-1:0]                wr_col;

   assign row_next  = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
   // oldest row sits right after the write pointer
   assign view_sum  = SW'(row_ff) + SW'(1) + SW'(cmd.view_row);
   assign view_wrap = (view_sum >= ROWS_S) ? view_sum - ROWS_S : view_sum;
   assign view_phys = view_wrap[RW-1:0];
   assign new_row   = ~line_open_ff | (col_ff >= COLS_C);
   assign wr_row    = new_row ? row_next : row_ff;
   assign wr_col    = new_row ? '0 : col_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tclb_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = tclb_pkg::ST_RUN;
            end
         end
         tclb_pkg::ST_RUN: begin
            if (cmd_valid && cmd.op == tclb_pkg::OP_END) begin
               state_in = tclb_pkg::ST_PAD;
            end
         end
         tclb_pkg::ST_PAD: begin
            if (col_ff >= COLS_C) begin
               state_in = tclb_pkg::ST_RUN;
            end
         end
         default: state_in = tclb_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = {row_ff, col_ff[CAW-1:0]};
      mem_wdata     = pad_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      line_open_in  = line_open_ff;
      clr_addr_in   = clr_addr_ff;
      rd_pending_in = 1'b0;
      rd_zero_in    = rd_zero_ff;
      case (state_ff)
         tclb_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_wdata   = tclb_pkg::RESET_PAD;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         tclb_pkg::ST_RUN: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  tclb_pkg::OP_READ: begin
                     mem_re        = 1'b1;
                     mem_addr      = {view_phys, cmd.view_col[CAW-1:0]};
                     rd_pending_in = 1'b1;
                     rd_zero_in    = ~cmd.in_range;
                  end
                  tclb_pkg::OP_WRITE: begin
                     mem_we       = 1'b1;
                     mem_addr     = {wr_row, wr_col[CAW-1:0]};
                     mem_wdata    = cmd.char_byte;
                     row_in       = wr_row;
                     col_in       = wr_col + 1'b1;
                     line_open_in = 1'b1;
                  end
                  tclb_pkg::OP_END: begin
                     // empty line opens a fresh row before padding
                     if (!line_open_ff) begin
                        row_in = row_next;
                        col_in = '0;
                     end
                     line_open_in = 1'b0;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         tclb_pkg::ST_PAD: begin
            if (col_ff < COLS_C) begin
               mem_we = 1'b1;
               col_in = col_ff + 1'b1;
            end
         end
         default: begin
            clr_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tclb_pkg::ST_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         line_open_ff  <= 1'b0;
         clr_addr_ff   <= '0;
         pad_ff        <= tclb_pkg::RESET_PAD;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         line_open_ff  <= line_open_in;
         clr_addr_ff   <= clr_addr_in;
         rd_pending_ff <= rd_pending_in;
         if (csr_write_en) begin
            pad_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_zero_ff <= rd_zero_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   assign status.clearing = (state_ff == tclb_pkg::ST_CLEAR);
   assign strobe          = rd_pending_ff;
   assign rsp_cell_word   = rd_zero_ff ? '0
                                       : (tclb_pkg::CELL_COLOR | {8'h00, mem_q_ff});

endmodule

### verif/tclb_screen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tclb_screen_checker
// Mirrors the console screen on every accepted beat and checks each read
// strobe against the cell word that the mirror predicts.
// ----------------------------------------------------------------------------
module tclb_screen_checker #(
   parameter int unsigned ROWS = 25,
   parameter int unsigned COLS = 80
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_func,
   input  logic [tclb_pkg::CHAR_W-1:0]         req_char_byte,
   input  logic [tclb_pkg::VIEW_ROW_W-1:0]     req_view_row,
   input  logic [tclb_pkg::VIEW_COL_W-1:0]     req_view_col,
   input  logic                                strobe,
   input  logic [tclb_pkg::CELL_W-1:0]         rsp_cell_word,
   input  logic                                csr_write_en,
   input  logic [tclb_pkg::CHAR_W-1:0]         csr_write_data,
   output int                                  fail_count,
   output int                                  pending_cells
);

   localparam logic [tclb_pkg::CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned COL_W = $clog2(COLS + 1);

   logic [tclb_pkg::CHAR_W-1:0] screen_chars [ROWS*COLS];
   logic [tclb_pkg::CHAR_W-1:0] pad_value;
   logic [ROW_W-1:0]            row_ptr;
   logic [COL_W-1:0]            col_count;
   logic                        line_open;
   logic [tclb_pkg::CELL_W-1:0] cell_words_due [$];
   int                          errors = 0;

   function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
   endfunction

   task automatic store_char(input logic [tclb_pkg::CHAR_W-1:0] ch);
      if (col_count < COLS) begin
         screen_chars[row_ptr * COLS + col_count] = ch;
         col_count++;
      end
   endtask

   task automatic predict_console_beat(input logic                            func,
                                       input logic [tclb_pkg::CHAR_W-1:0]     ch,
                                       input logic [tclb_pkg::VIEW_ROW_W-1:0] vr,
                                       input logic [tclb_pkg::VIEW_COL_W-1:0] vc);
      int unsigned                 src_row;
      logic [tclb_pkg::CELL_W-1:0] word;
      if (func == tclb_pkg::FUNC_READ) begin
         word = '0;
         if (vr < ROWS && vc < COLS) begin
            // display row 0 is the row just after the pointer (oldest)
            src_row = (row_ptr + 1 + vr) % ROWS;
            word    = tclb_pkg::CELL_COLOR
                      | tclb_pkg::CELL_W'(screen_chars[src_row * COLS + vc]);
         end
         cell_words_due.push_back(word);
      end else begin
         if (!line_open) begin
            row_ptr   = next_row(row_ptr);
            col_count = '0;
            line_open = 1'b1;
         end else if (ch != tclb_pkg::LINE_END && col_count >= COLS) begin
            row_ptr   = next_row(row_ptr);
            col_count = '0;
         end
         if (ch == tclb_pkg::LINE_END) begin
            while (col_count < COLS) store_char(pad_value);
            line_open = 1'b0;
         end else begin
            store_char(ch);
         end
      end
   endtask

   always @(posedge clock) begin : track_beats
      logic [tclb_pkg::CELL_W-1:0] due;
      if (reset) begin
         pad_value = tclb_pkg::RESET_PAD;
         row_ptr   = '0;
         col_count = '0;
         line_open = 1'b0;
         foreach (screen_chars[i]) screen_chars[i] = SPACE_CHAR;
         cell_words_due.delete();
      end else begin
         // retire the result beat before queuing a new read
         if (strobe) begin
            if (cell_words_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected cell word: expected none, actual %h",
                        $time, rsp_cell_word);
            end else begin
               due = cell_words_due.pop_front();
               if (rsp_cell_word !== due) begin
                  errors++;
                  $display("%0t: cell word mismatch: expected %h, actual %h",
                           $time, due, rsp_cell_word);
               end
            end
         end
         if (csr_write_en) pad_value = csr_write_data;
         if (start && !busy)
            predict_console_beat(req_func, req_char_byte, req_view_row, req_view_col);
      end
      fail_count    <= errors;
      pending_cells <= cell_words_due.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives line bytes and cell reads into the console buffer under several
// pad characters and idle patterns; the screen checker scores the reads.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned ROWS = 25;
   localparam int unsigned COLS = 80;
   // a queued pair of line ends behind a running pad can keep the store busy
   localparam int unsigned SETTLE_CYCLES = 3 * (COLS + 2) + 10;
   // covers the post-reset clear sweep with margin
   localparam int unsigned STALL_LIMIT   = 10000;
   localparam int unsigned PHASE_BEATS   = 320;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            start          = 1'b0;
   logic                            busy;
   logic                            req_func       = tclb_pkg::FUNC_WRITE;
   logic [tclb_pkg::CHAR_W-1:0]     req_char_byte  = '0;
   logic [tclb_pkg::VIEW_ROW_W-1:0] req_view_row   = '0;
   logic [tclb_pkg::VIEW_COL_W-1:0] req_view_col   = '0;
   logic                            strobe;
   logic [tclb_pkg::CELL_W-1:0]     rsp_cell_word;
   logic                            csr_write_en   = 1'b0;
   logic [tclb_pkg::CHAR_W-1:0]     csr_write_data = '0;

   int fail_count;
   int pending_cells;
   int beats_sent   = 0;
   int idle_pct     = 0;
   int stall_cycles = 0;

   logic [tclb_pkg::CHAR_W-1:0] phase_pads [4];
   int                          phase_idle [4] = '{0, 54, 0, 36};

   always #1 clock = ~clock;

   text_console_line_buffer_core #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_byte  (req_char_byte),
      .req_view_row   (req_view_row),
      .req_view_col   (req_view_col),
      .strobe         (strobe),
      .rsp_cell_word  (rsp_cell_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   tclb_screen_checker #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_byte  (req_char_byte),
      .req_view_row   (req_view_row),
      .req_view_col   (req_view_col),
      .strobe         (strobe),
      .rsp_cell_word  (rsp_cell_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_cells  (pending_cells)
   );

   always @(posedge clock) begin
      if ((start && !busy) || strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // leaves start high after the accepting edge so back-to-back beats need no drop
   task automatic send_beat(input logic                            func,
                            input logic [tclb_pkg::CHAR_W-1:0]     ch,
                            input logic [tclb_pkg::VIEW_ROW_W-1:0] vr,
                            input logic [tclb_pkg::VIEW_COL_W-1:0] vc);
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < idle_pct);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_char_byte <= ch;
      req_view_row  <= vr;
      req_view_col  <= vc;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_write(input logic [tclb_pkg::CHAR_W-1:0] ch);
      send_beat(tclb_pkg::FUNC_WRITE, ch,
                tclb_pkg::VIEW_ROW_W'($urandom_range(31, 0)),
                tclb_pkg::VIEW_COL_W'($urandom_range(127, 0)));
   endtask

   task automatic send_read(input int vr, input int vc);
      send_beat(tclb_pkg::FUNC_READ, tclb_pkg::CHAR_W'($urandom_range(255, 0)),
                tclb_pkg::VIEW_ROW_W'(vr), tclb_pkg::VIEW_COL_W'(vc));
   endtask

   task automatic send_random_read();
      if ($urandom_range(9, 0) == 0)
         send_read($urandom_range(31, 0), $urandom_range(127, 0));
      else
         send_read($urandom_range(ROWS - 1, 0), $urandom_range(COLS - 1, 0));
   endtask

   function automatic int random_line_len();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 60) return $urandom_range(12, 0);
      if (pick < 68) return $urandom_range(COLS + 1, COLS - 1);
      if (pick < 73) return $urandom_range(2 * COLS + 1, COLS + 2);
      return $urandom_range(COLS - 2, 13);
   endfunction

   // reads mixed into an open line see partly written rows
   task automatic send_line(input int len);
      for (int i = 0; i < len; i++) begin
         send_write(tclb_pkg::CHAR_W'($urandom_range(255, 1)));
         if ($urandom_range(4, 0) == 0) send_random_read();
      end
      send_write(tclb_pkg::LINE_END);
   endtask

   task automatic wait_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_cells != 0) @(posedge clock);
   endtask

   // pads run on after the last read strobe, so hold off before touching the csr
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pad(input logic [tclb_pkg::CHAR_W-1:0] pad);
      csr_write_en   <= 1'b1;
      csr_write_data <= pad;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic run_traffic(input int beats);
      int stop_at;
      int pick;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99, 0);
         if (pick < 55) send_line(random_line_len());
         else if (pick < 90) repeat ($urandom_range(6, 1)) send_random_read();
         else if (pick < 97) send_write(tclb_pkg::CHAR_W'($urandom_range(255, 0)));
         else wait_results();
      end
   endtask

   initial begin
      phase_pads = '{8'h00, 8'hFF, tclb_pkg::CHAR_W'($urandom_range(255, 0)), 8'h20};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_pad(8'h2E);

      // fresh screen, both corners, out-of-range reads
      send_read(0, 0);
      send_read(ROWS - 1, COLS - 1);
      send_read(ROWS, 0);
      send_read(0, COLS);
      send_read(31, 127);
      // empty line pads a whole row
      send_write(tclb_pkg::LINE_END);
      send_read(ROWS - 1, 0);
      send_read(ROWS - 1, COLS - 1);
      // open line: written cells show, the rest still holds old text
      send_write(8'hFF);
      send_write(8'h01);
      send_write(8'h80);
      send_read(ROWS - 1, 0);
      send_read(ROWS - 1, 2);
      send_read(ROWS - 1, 3);
      send_write(tclb_pkg::LINE_END);
      send_read(ROWS - 1, 3);
      send_read(ROWS - 2, 0);
      send_read(0, 0);

      foreach (phase_pads[p]) begin
         settle();
         write_pad(phase_pads[p]);
         idle_pct = phase_idle[p];
         run_traffic(PHASE_BEATS);
      end

      settle();
      if (fail_count == 0 && pending_cells == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
